// ===== rtl/ikxc_pkg.sv =====
// ----------------------------------------------------------------------------
// ikxc_pkg - shared types and constants of the ISAAC keystream XOR cipher
// Command and error codes, controller states, datapath operations and the
// mixing helpers used by the key set-up and the generator round.
// ----------------------------------------------------------------------------
package ikxc_pkg;

   // request command codes
   localparam logic [1:0] CMD_KEY   = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_DATA  = 2'd2;

   // result error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_KEY_FULL  = 2'd1;
   localparam logic [1:0] ERR_KEY_EMPTY = 2'd2;

   localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ERR_FULL,
      ST_ERR_EMPTY,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_MIX_INIT,
      ST_INIT_SCR,
      ST_SEED_RD,
      ST_SEED_ADD,
      ST_SEED_SCR,
      ST_SEED_WR,
      ST_FINISH,
      ST_GEN_START,
      ST_G0,
      ST_G1,
      ST_G2,
      ST_G3,
      ST_G4,
      ST_G5,
      ST_DATA_RD,
      ST_DATA_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_KEY_WR,
      OP_START,
      OP_ERR_FULL,
      OP_ERR_EMPTY,
      OP_FILL_RD,
      OP_FILL_WR,
      OP_MIX_INIT,
      OP_INIT_SCR,
      OP_SEED_RD,
      OP_SEED_ADD,
      OP_SEED_SCR,
      OP_SEED_WR,
      OP_FINISH,
      OP_GEN_START,
      OP_G0,
      OP_G1,
      OP_G2,
      OP_G3,
      OP_G4,
      OP_G5,
      OP_DATA_RD,
      OP_DATA_OUT
   } dp_op_type;

   typedef struct packed {
      logic      accept;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic key_full;
      logic key_empty;
      logic bl_zero;
      logic fill_last;
      logic step_last;
      logic scr_last;
      logic widx_last;
      logic blk_last;
      logic pass_second;
   } dp_status_type;

   // shift term of one scramble step
   function automatic logic [31:0] scramble_shift(input logic [2:0] step,
                                                  input logic [31:0] v);
      logic [31:0] r;
      case (step)
         3'd0:    r = v << 11;
         3'd1:    r = v >> 2;
         3'd2:    r = v << 8;
         3'd3:    r = v >> 16;
         3'd4:    r = v << 10;
         3'd5:    r = v >> 4;
         3'd6:    r = v << 8;
         3'd7:    r = v >> 9;
         default: r = v;
      endcase
      return r;
   endfunction

   // a ^ shifted a, shift chosen by the low word index bits
   function automatic logic [31:0] gen_mix(input logic [1:0] sel, input logic [31:0] a);
      logic [31:0] r;
      case (sel)
         2'd0:    r = a ^ (a << 13);
         2'd1:    r = a ^ (a >> 6);
         2'd2:    r = a ^ (a << 2);
         2'd3:    r = a ^ (a >> 16);
         default: r = a;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ikxc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ikxc_ctrl - sequencer of the ISAAC keystream XOR cipher
// Handshakes, state machine and result valid; issues one datapath op a cycle unless waiting on req or a stalled result.
// ----------------------------------------------------------------------------
module ikxc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ikxc_pkg::dp_status_type dp_status,
   output ikxc_pkg::dp_cmd_type    dp_cmd
);
   import ikxc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free, rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_load      = 1'b0;
      dp_cmd.accept = accept;
      dp_cmd.op     = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_KEY: begin
                     if (dp_status.key_full) state_in = ST_ERR_FULL;
                     else dp_cmd.op = OP_KEY_WR;
                  end
                  CMD_START: begin
                     if (dp_status.key_empty) state_in = ST_ERR_EMPTY;
                     else begin
                        dp_cmd.op = OP_START;
                        state_in  = ST_FILL_RD;
                     end
                  end
                  CMD_DATA: begin
                     if (dp_status.bl_zero) state_in = ST_GEN_START;
                     else begin
                        dp_cmd.op = OP_DATA_RD;
                        state_in  = ST_DATA_OUT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ERR_FULL: begin
            if (out_free) begin
               dp_cmd.op = OP_ERR_FULL;
               rsp_load  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_ERR_EMPTY: begin
            if (out_free) begin
               dp_cmd.op = OP_ERR_EMPTY;
               rsp_load  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_FILL_RD: begin
            dp_cmd.op = OP_FILL_RD;
            state_in  = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            dp_cmd.op = OP_FILL_WR;
            state_in  = dp_status.fill_last ? ST_MIX_INIT : ST_FILL_RD;
         end
         ST_MIX_INIT: begin
            dp_cmd.op = OP_MIX_INIT;
            state_in  = ST_INIT_SCR;
         end
         ST_INIT_SCR: begin
            dp_cmd.op = OP_INIT_SCR;
            if (dp_status.step_last && dp_status.scr_last) state_in = ST_SEED_RD;
         end
         ST_SEED_RD: begin
            dp_cmd.op = OP_SEED_RD;
            state_in  = ST_SEED_ADD;
         end
         ST_SEED_ADD: begin
            dp_cmd.op = OP_SEED_ADD;
            state_in  = dp_status.step_last ? ST_SEED_SCR : ST_SEED_RD;
         end
         ST_SEED_SCR: begin
            dp_cmd.op = OP_SEED_SCR;
            if (dp_status.step_last) state_in = ST_SEED_WR;
         end
         ST_SEED_WR: begin
            dp_cmd.op = OP_SEED_WR;
            if (dp_status.step_last) begin
               if (dp_status.blk_last && dp_status.pass_second) state_in = ST_FINISH;
               else state_in = ST_SEED_RD;
            end
         end
         ST_FINISH: begin
            dp_cmd.op = OP_FINISH;
            state_in  = ST_IDLE;
         end
         ST_GEN_START: begin
            dp_cmd.op = OP_GEN_START;
            state_in  = ST_G0;
         end
         ST_G0: begin
            dp_cmd.op = OP_G0;
            state_in  = ST_G1;
         end
         ST_G1: begin
            dp_cmd.op = OP_G1;
            state_in  = ST_G2;
         end
         ST_G2: begin
            dp_cmd.op = OP_G2;
            state_in  = ST_G3;
         end
         ST_G3: begin
            dp_cmd.op = OP_G3;
            state_in  = ST_G4;
         end
         ST_G4: begin
            dp_cmd.op = OP_G4;
            state_in  = ST_G5;
         end
         ST_G5: begin
            dp_cmd.op = OP_G5;
            state_in  = dp_status.widx_last ? ST_DATA_RD : ST_G0;
         end
         ST_DATA_RD: begin
            dp_cmd.op = OP_DATA_RD;
            state_in  = ST_DATA_OUT;
         end
         ST_DATA_OUT: begin
            if (out_free) begin
               dp_cmd.op = OP_DATA_OUT;
               rsp_load  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

`ifndef ASSERT_OFF
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DATA_OUT || state_ff == ST_ERR_FULL
                                    || state_ff == ST_ERR_EMPTY))
      else $error("result raised outside an output state");
   a_start_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_START && !dp_status.key_empty) |=> state_ff == ST_FILL_RD)
      else $error("start with key did not enter fill");
   a_gen_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_G5 && dp_status.widx_last) |=> (state_ff == ST_DATA_RD
                                                       && !dp_status.bl_zero))
      else $error("round end did not refill byte count");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("stalled result overwritten");
`endif

endmodule

// ===== rtl/ikxc_datapath.sv =====
// ----------------------------------------------------------------------------
// ikxc_datapath - stores and arithmetic of the ISAAC keystream XOR cipher
// Key store, word and result memories, mixer words, generator accumulators.
// ----------------------------------------------------------------------------
module ikxc_datapath #(
   parameter int LOG_TABLE_WORDS = 8,
   parameter int KEY_BYTES_MAX   = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ikxc_pkg::dp_cmd_type    dp_cmd,
   input  logic [7:0]              req_in_byte,
   output ikxc_pkg::dp_status_type dp_status,
   output logic [7:0]              rsp_out_byte,
   output logic [1:0]              rsp_error_code
);
   import ikxc_pkg::*;

   localparam int LW  = LOG_TABLE_WORDS;
   localparam int TW  = 1 << LW;
   localparam int TB  = 4 * TW;
   localparam int BLW = LW + 3;
   localparam int BCW = LW + 2;
   localparam int BKW = LW - 3;
   localparam int KAW = $clog2(KEY_BYTES_MAX);
   localparam int KCW = $clog2(KEY_BYTES_MAX + 1);

   logic [31:0] wm_mem [TW];
   logic [31:0] rw_mem [TW];
   logic [7:0]  ks_mem [KEY_BYTES_MAX];

   logic          wm_we, rw_we, rw_re, ks_we;
   logic [LW-1:0] wm_waddr, wm_raddr, rw_waddr, rw_raddr;
   logic [31:0]   wm_wdata, rw_wdata;
   logic [KAW-1:0] ks_waddr, ks_raddr;
   logic [31:0]   wm_rd_ff, rw_rd_ff;
   logic [7:0]    ks_rd_ff;

   logic [KCW-1:0] key_count_ff, key_count_in;
   logic [KAW-1:0] kidx_ff, kidx_in;
   logic [KCW-1:0] kidx_p1;
   logic [BCW-1:0] bcnt_ff, bcnt_in;
   logic [31:0]    wacc_ff, wacc_in;
   logic [BLW-1:0] bl_ff, bl_in, bl_m1;
   logic [LW-1:0]  widx_ff, widx_in;
   logic [BKW-1:0] blk_ff, blk_in;
   logic [2:0]     step_ff, step_in;
   logic [1:0]     scr_ff, scr_in;
   logic           pass_ff, pass_in;
   logic [31:0]    mix_ff [8];
   logic [31:0]    mix_in [8];
   logic [31:0]    a_ff, a_in, b_ff, b_in, rc_ff, rc_in;
   logic [31:0]    x_ff, x_in, y_ff, y_in;
   logic [7:0]     byte_ff, byte_in, out_ff, out_in;
   logic [1:0]     err_ff, err_in;

   logic [31:0]    scr_t, seed_src;
   logic [31:0]    scr_w [8];
   logic [31:0]    scr_rot [8];
   logic [31:0]    add_rot [8];
   logic [31:0]    mix_rot [8];
   logic [7:0]     ks_sel;

   // memories
   always_ff @(posedge clock) begin
      if (wm_we) wm_mem[wm_waddr] <= wm_wdata;
      wm_rd_ff <= wm_mem[wm_raddr];
   end

   always_ff @(posedge clock) begin
      if (rw_we) rw_mem[rw_waddr] <= rw_wdata;
      if (rw_re) rw_rd_ff <= rw_mem[rw_raddr];
   end

   always_ff @(posedge clock) begin
      if (ks_we) ks_mem[ks_waddr] <= req_in_byte;
      ks_rd_ff <= ks_mem[ks_raddr];
   end

   // one scramble step on positions 0..3, then rotate by one word
   always_comb begin
      scr_t = mix_ff[0] ^ scramble_shift(step_ff, mix_ff[1]);
      for (int k = 0; k < 8; k++) scr_w[k] = mix_ff[k];
      scr_w[0] = scr_t;
      scr_w[1] = mix_ff[1] + mix_ff[2];
      scr_w[3] = mix_ff[3] + scr_t;
      for (int k = 0; k < 8; k++) begin
         scr_rot[k] = scr_w[(k + 1) % 8];
         mix_rot[k] = mix_ff[(k + 1) % 8];
      end
      for (int k = 0; k < 7; k++) add_rot[k] = mix_ff[k + 1];
      add_rot[7] = mix_ff[0] + seed_src;
   end

   assign seed_src = pass_ff ? wm_rd_ff : rw_rd_ff;
   assign kidx_p1  = KCW'(kidx_ff) + KCW'(1);
   assign bl_m1    = bl_ff - BLW'(1);
   assign ks_sel   = rw_rd_ff[{bl_ff[1:0], 3'b000} +: 8];

   always_comb begin
      wm_we = 1'b0; wm_waddr = widx_ff; wm_wdata = y_in; wm_raddr = widx_ff;
      rw_we = 1'b0; rw_waddr = widx_ff; rw_wdata = b_in; rw_re = 1'b0; rw_raddr = widx_ff;
      ks_we = 1'b0; ks_waddr = key_count_ff[KAW-1:0]; ks_raddr = kidx_ff;
      key_count_in = key_count_ff;
      kidx_in = kidx_ff; bcnt_in = bcnt_ff; wacc_in = wacc_ff; bl_in = bl_ff;
      widx_in = widx_ff; blk_in = blk_ff; step_in = step_ff; scr_in = scr_ff;
      pass_in = pass_ff;
      for (int k = 0; k < 8; k++) mix_in[k] = mix_ff[k];
      a_in = a_ff; b_in = b_ff; rc_in = rc_ff; x_in = x_ff; y_in = y_ff;
      byte_in = dp_cmd.accept ? req_in_byte : byte_ff;
      out_in = out_ff; err_in = err_ff;
      case (dp_cmd.op)
         OP_KEY_WR: begin
            ks_we        = 1'b1;
            key_count_in = key_count_ff + KCW'(1);
         end
         OP_START: begin
            kidx_in = '0;
            bcnt_in = '0;
         end
         OP_FILL_RD: begin
            kidx_in = (kidx_p1 >= key_count_ff) ? '0 : kidx_p1[KAW-1:0];
         end
         OP_FILL_WR: begin
            wacc_in  = {ks_rd_ff, wacc_ff[31:8]};
            rw_we    = (bcnt_ff[1:0] == 2'd3);
            rw_waddr = bcnt_ff[BCW-1:2];
            rw_wdata = wacc_in;
            bcnt_in  = bcnt_ff + BCW'(1);
         end
         OP_MIX_INIT: begin
            for (int k = 0; k < 8; k++) mix_in[k] = GOLDEN_RATIO;
            step_in = '0; scr_in = '0; pass_in = 1'b0; blk_in = '0;
         end
         OP_INIT_SCR: begin
            for (int k = 0; k < 8; k++) mix_in[k] = scr_rot[k];
            step_in = step_ff + 3'd1;
            if (&step_ff) scr_in = scr_ff + 2'd1;
         end
         OP_SEED_RD: begin
            rw_re    = !pass_ff;
            rw_raddr = {blk_ff, step_ff};
            wm_raddr = {blk_ff, step_ff};
         end
         OP_SEED_ADD: begin
            for (int k = 0; k < 8; k++) mix_in[k] = add_rot[k];
            step_in = step_ff + 3'd1;
         end
         OP_SEED_SCR: begin
            for (int k = 0; k < 8; k++) mix_in[k] = scr_rot[k];
            step_in = step_ff + 3'd1;
         end
         OP_SEED_WR: begin
            wm_we    = 1'b1;
            wm_waddr = {blk_ff, step_ff};
            wm_wdata = mix_ff[0];
            for (int k = 0; k < 8; k++) mix_in[k] = mix_rot[k];
            step_in = step_ff + 3'd1;
            if (&step_ff) begin
               blk_in = blk_ff + BKW'(1);
               if (&blk_ff) pass_in = 1'b1;
            end
         end
         OP_FINISH: begin
            a_in = '0; b_in = '0; rc_in = '0; bl_in = '0; key_count_in = '0;
         end
         OP_GEN_START: begin
            rc_in   = rc_ff + 32'd1;
            b_in    = b_ff + rc_ff + 32'd1;
            widx_in = '0;
         end
         OP_G0: wm_raddr = widx_ff;
         OP_G1: begin
            x_in     = wm_rd_ff;
            wm_raddr = widx_ff + LW'(TW / 2);
         end
         OP_G2: begin
            a_in     = gen_mix(widx_ff[1:0], a_ff) + wm_rd_ff;
            wm_raddr = x_ff[LW+1:2];
         end
         OP_G3: begin
            y_in     = wm_rd_ff + a_ff + b_ff;
            wm_we    = 1'b1;
            wm_waddr = widx_ff;
            wm_wdata = y_in;
         end
         OP_G4: wm_raddr = y_ff[2*LW+1:LW+2];
         OP_G5: begin
            b_in     = wm_rd_ff + x_ff;
            rw_we    = 1'b1;
            rw_waddr = widx_ff;
            rw_wdata = b_in;
            widx_in  = widx_ff + LW'(1);
            if (&widx_ff) bl_in = BLW'(TB);
         end
         OP_DATA_RD: begin
            bl_in    = bl_m1;
            rw_re    = 1'b1;
            rw_raddr = bl_m1[BCW-1:2];
         end
         OP_DATA_OUT: begin
            out_in = byte_ff ^ ks_sel;
            err_in = ERR_NONE;
         end
         OP_ERR_FULL: begin
            out_in = 8'd0;
            err_in = ERR_KEY_FULL;
         end
         OP_ERR_EMPTY: begin
            out_in = 8'd0;
            err_in = ERR_KEY_EMPTY;
         end
         default: out_in = out_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         bl_ff        <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         rc_ff        <= '0;
         kidx_ff      <= '0;
         bcnt_ff      <= '0;
         widx_ff      <= '0;
         blk_ff       <= '0;
         step_ff      <= '0;
         scr_ff       <= '0;
         pass_ff      <= 1'b0;
         for (int k = 0; k < 8; k++) mix_ff[k] <= '0;
      end else begin
         key_count_ff <= key_count_in;
         bl_ff        <= bl_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         rc_ff        <= rc_in;
         kidx_ff      <= kidx_in;
         bcnt_ff      <= bcnt_in;
         widx_ff      <= widx_in;
         blk_ff       <= blk_in;
         step_ff      <= step_in;
         scr_ff       <= scr_in;
         pass_ff      <= pass_in;
         for (int k = 0; k < 8; k++) mix_ff[k] <= mix_in[k];
      end
   end

   always_ff @(posedge clock) begin
      wacc_ff <= wacc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      byte_ff <= byte_in;
      out_ff  <= out_in;
      err_ff  <= err_in;
   end

   assign rsp_out_byte   = out_ff;
   assign rsp_error_code = err_ff;

   assign dp_status.key_full    = (key_count_ff >= KCW'(KEY_BYTES_MAX));
   assign dp_status.key_empty   = (key_count_ff == '0);
   assign dp_status.bl_zero     = (bl_ff == '0);
   assign dp_status.fill_last   = &bcnt_ff;
   assign dp_status.step_last   = &step_ff;
   assign dp_status.scr_last    = &scr_ff;
   assign dp_status.widx_last   = &widx_ff;
   assign dp_status.blk_last    = &blk_ff;
   assign dp_status.pass_second = pass_ff;

endmodule

// ===== rtl/isaac_keystream_xor_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// isaac_keystream_xor_cipher_unit - XOR stream cipher on an ISAAC generator
// Key bytes fill a key store; start seeds the generator; data bytes are
// XORed with keystream bytes, top byte of the result words first.
// ----------------------------------------------------------------------------
//  channel | ports                                | direction
//  --------+--------------------------------------+-----------
//  req     | req_valid req_stall req_cmd req_in_byte | in
//  rsp     | rsp_valid rsp_stall rsp_out_byte rsp_error_code | out
//
// Bytes: a key byte is stored as it is accepted; a data byte is accepted,
//    its result word read and the byte XORed; a generator round comes first once
//    every 4*2^L bytes: steps G0-G5 per word, one shared word-memory read port.
// Start: repeated key bytes fill 4*2^L bytes; the mixer is set up, then each
//    8-word seed block is added, scrambled and written back, in two passes.
// Reset: synchronous; clears counters, the generator accumulators and the mixer words.
// Stalls: one result register; a stalled result holds the sequencer in its
//    output state while the next transfer on req waits.
module isaac_keystream_xor_cipher_unit #(
   parameter int LOG_TABLE_WORDS = 8,
   parameter int KEY_BYTES_MAX   = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_error_code
);
   import ikxc_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: handshakes and one op per cycle unless waiting on req or a stalled result
   ikxc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // memories, mixer and generator arithmetic
   ikxc_datapath #(
      .LOG_TABLE_WORDS (LOG_TABLE_WORDS),
      .KEY_BYTES_MAX   (KEY_BYTES_MAX)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .req_in_byte    (req_in_byte),
      .dp_status      (dp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_error_code (rsp_error_code)
   );

endmodule
